/* design/msmf_pkg.sv */
// ----------------------------------------------------------------------------
// msmf_pkg
// Shared types and constants for the MIDI serial message framer.
// ----------------------------------------------------------------------------
package msmf_pkg;

	// framer phase, one-hot
	typedef enum logic [4:0] {
		PH_SYNC   = 5'b00001,
		PH_FIRST  = 5'b00010,
		PH_SECOND = 5'b00100,
		PH_LEN    = 5'b01000,
		PH_BODY   = 5'b10000
	} phase_t;

	// result kinds
	localparam logic KIND_MESSAGE = 1'b0;
	localparam logic KIND_COMMENT = 1'b1;

	// status high nibbles with a single data byte
	localparam logic [7:0] STATUS_HI_MASK    = 8'hF0;
	localparam logic [7:0] STATUS_PROG_CHG   = 8'hC0;
	localparam logic [7:0] STATUS_CHAN_PRESS = 8'hD0;

	// FF 00 00 opens a comment
	localparam logic [7:0] COMMENT_STATUS = 8'hFF;
	localparam logic [6:0] COMMENT_DATA   = 7'h00;

	// depth of the result queue in the top level
	localparam int unsigned RES_DEPTH = 3;
	localparam int unsigned RES_PTR_W = 2;

	typedef struct packed {
		logic       kind;
		logic [7:0] status_byte;
		logic [6:0] data_first;
		logic [6:0] data_second;
		logic [7:0] comment_byte;
		logic       comment_last;
	} result_t;

	function automatic logic single_data_status(input logic [7:0] s);
		logic [7:0] hi;
		hi = s & STATUS_HI_MASK;
		return (hi == STATUS_PROG_CHG) || (hi == STATUS_CHAN_PRESS);
	endfunction

endpackage

/* design/msmf_framer.sv */
// ----------------------------------------------------------------------------
// msmf_framer
// Framer state and per-byte next-state / result logic.
// ----------------------------------------------------------------------------
module msmf_framer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	input  logic [7:0]        byte_in,
	input  logic              quiet,
	output logic              res_valid,
	output msmf_pkg::result_t res
);

	msmf_pkg::phase_t phase_q, phase_d;
	logic [7:0] run_status_q, run_status_d;
	logic [6:0] first_q, first_d;
	logic [6:0] second_q, second_d;
	logic [7:0] remain_q, remain_d;
	logic [7:0] remain_dec;
	logic       is_status;
	logic       emit;
	logic       opens_comment;

	assign is_status  = byte_in[7];
	assign remain_dec = (remain_q != 8'd0) ? (remain_q - 8'd1) : 8'd0;

	always_comb begin
		phase_d      = phase_q;
		run_status_d = run_status_q;
		first_d      = first_q;
		second_d     = second_q;
		remain_d     = remain_q;
		emit         = 1'b0;
		res_valid    = 1'b0;
		res          = '0;
		case (phase_q)
			msmf_pkg::PH_SYNC: begin
				if (is_status) begin
					run_status_d = byte_in;
					phase_d      = msmf_pkg::PH_FIRST;
				end
			end
			msmf_pkg::PH_FIRST: begin
				if (is_status) begin
					run_status_d = byte_in;
				end else begin
					first_d = byte_in[6:0];
					if (msmf_pkg::single_data_status(run_status_q)) begin
						emit = 1'b1;
					end else begin
						phase_d = msmf_pkg::PH_SECOND;
					end
				end
			end
			msmf_pkg::PH_SECOND: begin
				if (is_status) begin
					run_status_d = byte_in;
					phase_d      = msmf_pkg::PH_FIRST;
				end else begin
					second_d = byte_in[6:0];
					emit     = 1'b1;
				end
			end
			msmf_pkg::PH_LEN: begin
				// length byte is raw and becomes the running status
				run_status_d = byte_in;
				remain_d     = byte_in;
				phase_d      = (byte_in == 8'd0) ? msmf_pkg::PH_FIRST : msmf_pkg::PH_BODY;
			end
			msmf_pkg::PH_BODY: begin
				remain_d = remain_dec;
				if (remain_dec == 8'd0) begin
					phase_d = msmf_pkg::PH_FIRST;
				end
				if (!quiet) begin
					res_valid          = 1'b1;
					res.kind           = msmf_pkg::KIND_COMMENT;
					res.comment_byte   = byte_in;
					res.comment_last   = (remain_dec == 8'd0);
				end
			end
			default: begin
				phase_d = msmf_pkg::PH_SYNC;
			end
		endcase
		// FF 00 00 with the values after this byte
		opens_comment = (run_status_q == msmf_pkg::COMMENT_STATUS) &&
			(first_d == msmf_pkg::COMMENT_DATA) && (second_d == msmf_pkg::COMMENT_DATA);
		if (emit) begin
			if (opens_comment) begin
				phase_d = msmf_pkg::PH_LEN;
			end else begin
				phase_d         = msmf_pkg::PH_FIRST;
				res_valid       = 1'b1;
				res.kind        = msmf_pkg::KIND_MESSAGE;
				res.status_byte = run_status_q;
				res.data_first  = first_d;
				res.data_second = second_d;
			end
		end
		if (!byte_valid) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= msmf_pkg::PH_SYNC;
			run_status_q <= 8'd0;
			first_q      <= 7'd0;
			second_q     <= 7'd0;
			remain_q     <= 8'd0;
		end else if (byte_valid) begin
			phase_q      <= phase_d;
			run_status_q <= run_status_d;
			first_q      <= first_d;
			second_q     <= second_d;
			remain_q     <= remain_d;
		end
	end

	// body bytes only come out of the body phase
	a_comment_from_body: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == msmf_pkg::KIND_COMMENT) |-> (phase_q == msmf_pkg::PH_BODY))
		else $error("comment byte outside comment body");

	// a comment never outlives its length
	a_body_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == msmf_pkg::PH_BODY) |-> (remain_q != 8'd0))
		else $error("comment body phase with zero count");

	// exactly one phase at a time
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("phase register not one-hot");

endmodule

/* design/midi_serial_message_framer_top.sv */
// ----------------------------------------------------------------------------
// midi_serial_message_framer_top
// Frames a received serial byte stream into MIDI messages and comment bytes.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle while in_ready is high. An accepted byte is
// registered, the framer updates its state from it in the next cycle and any
// result is written at the end of that cycle into a three-entry result queue
// whose head drives the output ports, so a result is offered once it reaches
// the head. The queue lets the input keep taking bytes while the head result
// waits; in_ready only drops when the queue plus the byte in flight would
// leave no room. Data bytes are dropped until the first status byte; running
// status is kept; program change and channel pressure emit after one data
// byte with the stale second byte. FF 00 00 is not emitted but opens a
// comment: a length byte (which also becomes the running status) and that
// many raw body bytes, each emitted with kind 1 unless comment_quiet is set.
// Write comment_quiet only while the block is idle.
module midi_serial_message_framer_top (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	// byte input
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	// result output
	output logic       out_valid,
	input  logic       out_ready,
	output logic       kind,
	output logic [7:0] status_byte,
	output logic [6:0] data_first,
	output logic [6:0] data_second,
	output logic [7:0] comment_byte,
	output logic       comment_last
);

	localparam logic [msmf_pkg::RES_PTR_W-1:0] PTR_LAST =
		msmf_pkg::RES_PTR_W'(msmf_pkg::RES_DEPTH - 1);
	localparam logic [msmf_pkg::RES_PTR_W:0] DEPTH_CNT =
		(msmf_pkg::RES_PTR_W + 1)'(msmf_pkg::RES_DEPTH);

	logic                               comment_quiet_q;
	logic                               valid_s1;
	logic [7:0]                         byte_s1;
	logic                               res_valid;
	msmf_pkg::result_t                  res;
	msmf_pkg::result_t                  queue_q [msmf_pkg::RES_DEPTH];
	logic [msmf_pkg::RES_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [msmf_pkg::RES_PTR_W-1:0]     count_q;
	logic                               in_take, push, pop;
	msmf_pkg::result_t                  head;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comment_quiet_q <= 1'b0;
		end else if (cfg_wr_en) begin
			comment_quiet_q <= cfg_wr_data;
		end
	end

	// room for the new byte, the one in flight and those queued
	assign in_ready = ({1'b0, count_q} + {{msmf_pkg::RES_PTR_W{1'b0}}, valid_s1}) < DEPTH_CNT;
	assign in_take  = in_valid && in_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= rx_byte;
		end
	end

	msmf_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(valid_s1),
		.byte_in   (byte_s1),
		.quiet     (comment_quiet_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// result queue
	assign push = res_valid;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= res;
		end
	end

	assign head         = queue_q[rd_ptr_q];
	assign out_valid    = (count_q != '0);
	assign kind         = head.kind;
	assign status_byte  = head.status_byte;
	assign data_first   = head.data_first;
	assign data_second  = head.data_second;
	assign comment_byte = head.comment_byte;
	assign comment_last = head.comment_last;

	// the queue never overflows
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> ({1'b0, count_q} < DEPTH_CNT))
		else $error("result queue overflow");

	// a byte in flight always has a free queue slot
	a_slot_for_flight: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ({1'b0, count_q} < DEPTH_CNT))
		else $error("no queue slot for byte in flight");

	// a waiting result is neither lost nor changed
	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(head)))
		else $error("waiting result dropped or changed");

endmodule
